>>> hdl/mmec_pkg.sv
// ----------------------------------------------------------------------------
// mmec_pkg
// Shared types and constants of the move machine execute core: instruction
// field positions, special register codes and the structs between modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mmec_pkg;

  localparam int unsigned DATA_W   = 8;
  localparam int unsigned INSTR_W  = 10;
  localparam int unsigned REG_W    = 4;
  localparam int unsigned PC_W     = 8;

  // Instruction fields
  localparam int unsigned OPC_COPY_BIT = 9;
  localparam int unsigned IMM_HI_BIT   = 8;
  localparam int unsigned DEST_LSB     = 4;
  localparam int unsigned SRC_LSB      = 0;

  // Special register codes
  localparam logic [REG_W-1:0] REG_ZERO     = 4'd0;
  localparam logic [REG_W-1:0] REG_PRINT    = 4'd1;
  localparam logic [REG_W-1:0] REG_GP0      = 4'd2;
  localparam logic [REG_W-1:0] REG_GP1      = 4'd3;
  localparam logic [REG_W-1:0] REG_GP2      = 4'd4;
  localparam logic [REG_W-1:0] REG_GP3      = 4'd5;
  localparam logic [REG_W-1:0] REG_NOR      = 4'd6;
  localparam logic [REG_W-1:0] REG_XOR      = 4'd7;
  localparam logic [REG_W-1:0] REG_ADD      = 4'd8;
  localparam logic [REG_W-1:0] REG_OPND     = 4'd9;
  localparam logic [REG_W-1:0] REG_SUB      = 4'd10;
  localparam logic [REG_W-1:0] REG_HALVE    = 4'd11;
  localparam logic [REG_W-1:0] REG_BR_COND  = 4'd12;
  localparam logic [REG_W-1:0] REG_BR_ADDR  = 4'd13;
  localparam logic [REG_W-1:0] REG_RAM_ADDR = 4'd14;
  localparam logic [REG_W-1:0] REG_RAM_DATA = 4'd15;

  localparam logic [PC_W-1:0] PC_RESET = 8'd1;

  typedef struct packed {
    logic              en;
    logic              we;
    logic [DATA_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } ram_req_t;

  typedef struct packed {
    logic [PC_W-1:0]   fetch_addr;
    logic              print_valid;
    logic [DATA_W-1:0] print_value;
    logic              halted;
  } result_t;

endpackage

`default_nettype wire

>>> hdl/move_machine_execute_core_top.sv
// ----------------------------------------------------------------------------
// move_machine_execute_core_top
// Execute core of an 8-bit transport-triggered machine with 16 special
// registers; one 10-bit instruction in, one status beat out.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one instruction word per beat, fetched by the
//   caller from the address reported in the previous output beat (address 1
//   first after reset). Each instruction gives exactly one output beat with
//   the next fetch address, the print latch and the halt flag.
//   An instruction is held in an input register and executed from there once
//   the output register is free or being taken; then the special registers,
//   units, branch pipe and the data RAM are updated and the output register
//   is loaded. Throughput is one instruction per cycle while the receiver
//   takes each beat; the loop through the register file and PC sets it.
//   The next instruction is taken while an earlier result still waits, and
//   a stalled receiver holds the output register, which in turn holds the
//   input register; nothing is dropped.
//   Reset (rst_n low, synchronous) clears the control and special registers,
//   unit and branch stages and RAM contents (through per-entry valid bits),
//   and sets the program counter to 1. Both channels are empty after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module move_machine_execute_core_top #(
  parameter int unsigned RAM_DEPTH    = 256,
  parameter int unsigned BRANCH_DELAY = 6
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [mmec_pkg::INSTR_W-1:0]  in_instr_word,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [mmec_pkg::PC_W-1:0]          out_fetch_addr,
  output logic                               out_print_valid,
  output logic [mmec_pkg::DATA_W-1:0]        out_print_value,
  output logic                               out_halted
);

  logic                          ins_valid_r;
  logic [mmec_pkg::INSTR_W-1:0]  ins_word_r;
  logic                          exec_en;
  logic                          out_valid_r;
  mmec_pkg::result_t             res;
  mmec_pkg::result_t             res_r;
  mmec_pkg::ram_req_t            ram_req;
  logic [mmec_pkg::DATA_W-1:0]   ram_rdata;

  assign exec_en  = ins_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !ins_valid_r || exec_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ins_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        ins_valid_r <= in_valid;
      end
      if (exec_en) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ins_word_r <= in_instr_word;
    end
    if (exec_en) begin
      res_r <= res;
    end
  end

  mmec_core #(
    .BRANCH_DELAY (BRANCH_DELAY)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .exec_en   (exec_en),
    .instr     (ins_word_r),
    .ram_rdata (ram_rdata),
    .ram_req   (ram_req),
    .result    (res)
  );

  mmec_ram #(
    .RAM_DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  assign out_valid       = out_valid_r;
  assign out_fetch_addr  = res_r.fetch_addr;
  assign out_print_valid = res_r.print_valid;
  assign out_print_value = res_r.print_value;
  assign out_halted      = res_r.halted;

endmodule

`default_nettype wire

>>> hdl/mmec_ram.sv
// ----------------------------------------------------------------------------
// mmec_ram
// Data RAM behind special registers 14 and 15. Write-first, registered read,
// one valid bit per entry so that the whole array reads as zero after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module mmec_ram #(
  parameter int unsigned RAM_DEPTH = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire mmec_pkg::ram_req_t            req,
  output logic [mmec_pkg::DATA_W-1:0]        rdata
);

  localparam int unsigned AW      = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
  localparam int unsigned ADDR_SP = 1 << mmec_pkg::DATA_W;

  logic [AW-1:0]               idx_lut [ADDR_SP];
  logic [mmec_pkg::DATA_W-1:0] mem     [RAM_DEPTH];
  logic [RAM_DEPTH-1:0]        vld_r;
  logic [mmec_pkg::DATA_W-1:0] rdata_r;
  logic [AW-1:0]               idx;

  // The byte address is folded onto the array depth through a constant table.
  for (genvar g = 0; g < ADDR_SP; g++) begin : g_lut
    assign idx_lut[g] = AW'(g % RAM_DEPTH);
  end

  assign idx = idx_lut[req.addr];

  always_ff @(posedge clk) begin
    if (req.en && req.we) begin
      mem[idx] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      rdata_r <= '0;
    end else if (req.en) begin
      if (req.we) begin
        vld_r[idx] <= 1'b1;
        rdata_r    <= req.wdata;
      end else begin
        rdata_r <= vld_r[idx] ? mem[idx] : '0;
      end
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> hdl/mmec_core.sv
// ----------------------------------------------------------------------------
// mmec_core
// Special register file, arithmetic units, branch pipe, program counter and
// halt flag. Executes one instruction whenever exec_en is high.
// ----------------------------------------------------------------------------
`default_nettype none

module mmec_core #(
  parameter int unsigned BRANCH_DELAY = 6
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          exec_en,
  input  wire logic [mmec_pkg::INSTR_W-1:0]  instr,
  input  wire logic [mmec_pkg::DATA_W-1:0]   ram_rdata,
  output mmec_pkg::ram_req_t                 ram_req,
  output mmec_pkg::result_t                  result
);

  localparam int unsigned DW = mmec_pkg::DATA_W;
  localparam int unsigned RW = mmec_pkg::REG_W;

  logic [DW-1:0] in_r   [1:15];
  logic [DW-1:0] in_nxt [1:15];

  logic [DW-1:0] nor_stage_r, nor_stage_nxt, nor_out_r;
  logic [DW-1:0] xor_stage_r, xor_stage_nxt, xor_out_r;
  logic [DW-1:0] add_stage_r, add_stage_nxt, add_out_r;
  logic [DW-1:0] sub_stage_r, sub_stage_nxt, sub_out_r;

  logic [BRANCH_DELAY-1:0] bv_r, bv_nxt, bv_eff;
  logic [DW-1:0]           bc_r   [BRANCH_DELAY];
  logic [DW-1:0]           bc_nxt [BRANCH_DELAY];

  logic [mmec_pkg::PC_W-1:0] pc_r, pc_nxt;
  logic                      halt_r, halt_nxt;

  logic [RW-1:0] dest;
  logic [RW-1:0] src;
  logic [DW-1:0] rd_val;
  logic [DW-1:0] imm;
  logic [DW-1:0] wval;
  logic          take_branch;

  assign dest = instr[mmec_pkg::DEST_LSB +: RW];
  assign src  = instr[mmec_pkg::SRC_LSB +: RW];

  // Read side of the transfer
  always_comb begin
    unique case (src) inside
      mmec_pkg::REG_PRINT, mmec_pkg::REG_GP0, mmec_pkg::REG_GP1,
      mmec_pkg::REG_GP2, mmec_pkg::REG_GP3: rd_val = in_r[src];
      mmec_pkg::REG_NOR:                    rd_val = nor_out_r;
      mmec_pkg::REG_XOR:                    rd_val = xor_out_r;
      mmec_pkg::REG_ADD:                    rd_val = add_out_r;
      mmec_pkg::REG_SUB:                    rd_val = sub_out_r;
      mmec_pkg::REG_HALVE:                  rd_val = in_r[mmec_pkg::REG_HALVE] >> 1;
      mmec_pkg::REG_RAM_ADDR:               rd_val = ram_rdata;
      default:                              rd_val = '0;
    endcase
  end

  assign imm  = instr[mmec_pkg::IMM_HI_BIT] ? {src, 4'h0} : {4'h0, src};
  assign wval = instr[mmec_pkg::OPC_COPY_BIT] ? rd_val : imm;

  always_comb begin
    for (int k = 1; k <= 15; k++) begin
      in_nxt[k] = in_r[k];
      if (dest == RW'(k)) begin
        in_nxt[k] = wval;
      end
    end
  end

  assign nor_stage_nxt = ~(in_nxt[mmec_pkg::REG_NOR] | in_nxt[mmec_pkg::REG_XOR]);
  assign xor_stage_nxt = in_nxt[mmec_pkg::REG_XOR] ^ in_nxt[mmec_pkg::REG_NOR];
  assign add_stage_nxt = in_nxt[mmec_pkg::REG_ADD] + in_nxt[mmec_pkg::REG_OPND];
  assign sub_stage_nxt = in_nxt[mmec_pkg::REG_OPND] - in_nxt[mmec_pkg::REG_SUB];

  // A write to the branch address arms the first stage before the pipe is
  // tested, so with a single stage the branch is taken in the same step.
  always_comb begin
    bv_eff    = bv_r;
    bv_eff[0] = bv_r[0] | (dest == mmec_pkg::REG_BR_ADDR);
    bv_nxt    = '0;
    bc_nxt[0] = in_nxt[mmec_pkg::REG_BR_COND];
    for (int k = 1; k < BRANCH_DELAY; k++) begin
      bv_nxt[k] = bv_eff[k-1];
      bc_nxt[k] = bc_r[k-1];
    end
  end

  assign take_branch = bv_eff[BRANCH_DELAY-1] && (bc_r[BRANCH_DELAY-1] == '0);
  assign pc_nxt      = take_branch ? in_nxt[mmec_pkg::REG_BR_ADDR] : pc_r + 1'b1;
  assign halt_nxt    = halt_r | (pc_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= 15; k++) begin
        in_r[k] <= '0;
      end
      for (int k = 0; k < BRANCH_DELAY; k++) begin
        bc_r[k] <= '0;
      end
      nor_stage_r <= '0;
      nor_out_r   <= '0;
      xor_stage_r <= '0;
      xor_out_r   <= '0;
      add_stage_r <= '0;
      add_out_r   <= '0;
      sub_stage_r <= '0;
      sub_out_r   <= '0;
      bv_r        <= '0;
      pc_r        <= mmec_pkg::PC_RESET;
      halt_r      <= 1'b0;
    end else if (exec_en) begin
      for (int k = 1; k <= 15; k++) begin
        in_r[k] <= in_nxt[k];
      end
      for (int k = 0; k < BRANCH_DELAY; k++) begin
        bc_r[k] <= bc_nxt[k];
      end
      nor_stage_r <= nor_stage_nxt;
      nor_out_r   <= nor_stage_r;
      xor_stage_r <= xor_stage_nxt;
      xor_out_r   <= xor_stage_r;
      add_stage_r <= add_stage_nxt;
      add_out_r   <= add_stage_r;
      sub_stage_r <= sub_stage_nxt;
      sub_out_r   <= sub_stage_r;
      bv_r        <= bv_nxt;
      pc_r        <= pc_nxt;
      halt_r      <= halt_nxt;
    end
  end

  assign ram_req.en    = exec_en;
  assign ram_req.we    = (dest == mmec_pkg::REG_RAM_DATA);
  assign ram_req.addr  = in_nxt[mmec_pkg::REG_RAM_ADDR];
  assign ram_req.wdata = in_nxt[mmec_pkg::REG_RAM_DATA];

  assign result.fetch_addr  = pc_nxt;
  assign result.print_valid = (dest == mmec_pkg::REG_PRINT);
  assign result.print_value = in_nxt[mmec_pkg::REG_PRINT];
  assign result.halted      = halt_nxt;

endmodule

`default_nettype wire
